/* design/riff_chunk_finder_macros.svh */
// assertion macros used by the riff chunk finder walker
`ifndef RIFF_CHUNK_FINDER_MACROS_SVH
`define RIFF_CHUNK_FINDER_MACROS_SVH

// same-cycle implication, checking held off while reset is low
`define RCF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checking held off while reset is low
`define RCF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rcf_pkg.sv */
// types, constants and helpers for the riff chunk finder
`timescale 1ns / 1ps
`default_nettype none

package rcf_pkg;

    localparam logic [31:0] TAG_RIFF         = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE         = 32'h4556_4157;
    localparam logic [31:0] DEFAULT_TARGET   = 32'h4C4D_5869;
    localparam logic [31:0] FILE_HDR_LEN     = 32'd12;
    localparam logic [33:0] CHUNK_HDR_LEN    = 34'd8;
    localparam logic [33:0] FIRST_CHUNK      = 34'd12;

    // configuration register indexes
    localparam logic CFG_FILE_LENGTH = 1'b0;
    localparam logic CFG_TARGET_ID   = 1'b1;

    typedef enum logic [1:0] {
        PH_FILE_HDR,
        PH_CHUNK_HDR,
        PH_SKIP,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [2:0] {
        ST_RUNNING,
        ST_FOUND,
        ST_TOO_SMALL,
        ST_NOT_WAV,
        ST_PAST_END,
        ST_NOT_FOUND
    } t_status;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       is_last;
        t_status    status;
    } t_result;

    // one byte of a four-byte tag, first byte in the low bits
    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
        return tag[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

/* design/rcf_out_reg.sv */
// result register between the chunk walker and the output stream
`timescale 1ns / 1ps
`default_nettype none

module rcf_out_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire rcf_pkg::t_result i_result,
    input  wire logic            i_ready,
    output logic                 o_valid,
    output rcf_pkg::t_result     o_result,
    output logic                 o_free
);
    import rcf_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

/* design/rcf_walker.sv */
// input register and per-byte riff header and chunk walk
`timescale 1ns / 1ps
`default_nettype none

module rcf_walker (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_first_byte,
    input  wire logic [31:0]     i_file_length,
    input  wire logic [31:0]     i_target_id,
    input  wire logic            i_out_free,
    output logic                 o_res_valid,
    output rcf_pkg::t_result     o_result
);
    import rcf_pkg::*;

    `include "riff_chunk_finder_macros.svh"

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_first;

    // walk state
    t_phase      r_phase,   n_phase,   c_phase;
    logic [31:0] r_count,   n_count,   c_count;
    logic [1:0]  r_shift,   n_shift,   c_shift;
    logic [31:0] r_id,      n_id,      c_id;
    logic [33:0] r_start,   n_start,   c_start;
    logic [31:0] r_left,    n_left,    c_left;
    logic        r_finished, n_finished, c_finished;

    logic        advance;
    logic        res_valid;
    t_result     result;
    logic [33:0] off;
    logic [33:0] pos_p1;
    logic [33:0] body;
    logic [33:0] body_end;
    logic [33:0] nxt;
    logic [33:0] flen;

    assign advance     = r_in_valid && i_out_free;
    assign o_ready     = !r_in_valid || advance;
    assign o_res_valid = advance && res_valid;
    assign o_result    = result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first_byte;
        end
    end

    always_comb begin
        // a first-byte marker restarts the walk before this byte is looked at
        if (r_in_first) begin
            c_phase    = PH_FILE_HDR;
            c_count    = '0;
            c_shift    = '0;
            c_id       = '0;
            c_start    = FIRST_CHUNK;
            c_left     = '0;
            c_finished = 1'b0;
        end else begin
            c_phase    = r_phase;
            c_count    = r_count;
            c_shift    = r_shift;
            c_id       = r_id;
            c_start    = r_start;
            c_left     = r_left;
            c_finished = r_finished;
        end

        n_phase    = c_phase;
        n_count    = c_count;
        n_shift    = c_shift;
        n_id       = c_id;
        n_start    = c_start;
        n_left     = c_left;
        n_finished = c_finished;

        res_valid  = 1'b0;
        result     = '{payload_byte: 8'd0, payload_valid: 1'b0, is_last: 1'b1,
                       status: ST_NOT_FOUND};

        flen     = {2'b00, i_file_length};
        off      = {2'b00, c_count} - c_start;
        pos_p1   = {2'b00, c_count} + 34'd1;
        body     = c_start + CHUNK_HDR_LEN;
        body_end = '0;
        nxt      = '0;

        if (!c_finished) begin
            n_count = c_count + 32'd1;
            case (c_phase)
                PH_FILE_HDR: begin
                    if (c_count == 32'd0 && i_file_length < FILE_HDR_LEN) begin
                        res_valid     = 1'b1;
                        result.status = ST_TOO_SMALL;
                    end else if (c_count < 32'd4) begin
                        if (r_in_byte != tag_byte(TAG_RIFF, c_count[1:0])) begin
                            res_valid     = 1'b1;
                            result.status = ST_NOT_WAV;
                        end
                    end else if (c_count >= 32'd8 && c_count < 32'd12) begin
                        if (r_in_byte != tag_byte(TAG_WAVE, c_count[1:0])) begin
                            res_valid     = 1'b1;
                            result.status = ST_NOT_WAV;
                        end else if (c_count == 32'd11) begin
                            n_start = FIRST_CHUNK;
                            if (FIRST_CHUNK + CHUNK_HDR_LEN > flen) begin
                                res_valid     = 1'b1;
                                result.status = ST_NOT_FOUND;
                            end else begin
                                n_phase = PH_CHUNK_HDR;
                                n_shift = '0;
                            end
                        end
                    end
                end

                PH_CHUNK_HDR: begin
                    // identifier bytes, then the little-endian size
                    if (off < 34'd4) begin
                        if (c_shift == 2'd0) begin
                            n_id = '0;
                        end
                        n_id[{c_shift, 3'b000} +: 8] = r_in_byte;
                    end else begin
                        if (c_shift == 2'd0) begin
                            n_left = '0;
                        end
                        n_left[{c_shift, 3'b000} +: 8] = r_in_byte;
                    end
                    n_shift = c_shift + 2'd1;
                    if (off == 34'd7) begin
                        body_end = body + {2'b00, n_left};
                        if (n_id == i_target_id) begin
                            if (body_end > flen) begin
                                res_valid     = 1'b1;
                                result.status = ST_PAST_END;
                            end else if (n_left == 32'd0) begin
                                res_valid     = 1'b1;
                                result.status = ST_FOUND;
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end else begin
                            // odd sizes carry a pad byte
                            nxt     = body_end + {33'd0, n_left[0]};
                            n_start = nxt;
                            if (nxt + CHUNK_HDR_LEN > flen) begin
                                res_valid     = 1'b1;
                                result.status = ST_NOT_FOUND;
                            end else if (nxt == pos_p1) begin
                                n_phase = PH_CHUNK_HDR;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                end

                PH_SKIP: begin
                    if (pos_p1 == c_start) begin
                        n_phase = PH_CHUNK_HDR;
                        n_shift = '0;
                    end
                end

                PH_PAYLOAD: begin
                    n_left               = c_left - 32'd1;
                    res_valid            = 1'b1;
                    result.payload_byte  = r_in_byte;
                    result.payload_valid = 1'b1;
                    if (n_left == 32'd0) begin
                        result.status = ST_FOUND;
                    end else begin
                        result.is_last = 1'b0;
                        result.status  = ST_RUNNING;
                    end
                end

                default: begin
                    n_phase = PH_FILE_HDR;
                end
            endcase

            if (res_valid && result.is_last) begin
                n_finished = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FILE_HDR;
            r_count    <= '0;
            r_shift    <= '0;
            r_id       <= '0;
            r_start    <= FIRST_CHUNK;
            r_left     <= '0;
            r_finished <= 1'b0;
        end else if (advance) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_shift    <= n_shift;
            r_id       <= n_id;
            r_start    <= n_start;
            r_left     <= n_left;
            r_finished <= n_finished;
        end
    end

    `RCF_ASSERT_IMP(a_payload_status, i_clk, i_rst_n,
        o_res_valid && o_result.payload_valid,
        o_result.status == ST_RUNNING || o_result.status == ST_FOUND,
        "payload item with a final error status")

    `RCF_ASSERT_IMP(a_running_has_payload, i_clk, i_rst_n,
        o_res_valid && !o_result.is_last,
        o_result.payload_valid && o_result.status == ST_RUNNING,
        "non-final item without payload")

    `RCF_ASSERT_NEXT(a_last_finishes, i_clk, i_rst_n,
        o_res_valid && o_result.is_last,
        r_finished,
        "walk not closed after final item")

    `RCF_ASSERT_IMP(a_payload_count, i_clk, i_rst_n,
        r_phase == PH_PAYLOAD && !r_finished,
        r_left != 32'd0,
        "payload phase with nothing left to send")

endmodule

`default_nettype wire

/* design/riff_chunk_finder.sv */
// top level of the riff chunk finder: config registers, walker, result register
//
//  channel   dir  handshake                   payload
//  -------   ---  --------------------------  ---------------------------------------
//  s (in)    in   i_s_tvalid / o_s_tready     tdata: data_byte, tuser: first_byte
//  m (out)   out  o_m_tvalid / i_m_tready     tdata: payload_byte, tlast: is_last,
//                                             tuser: payload_valid, status
//  cfg       in   i_cfg_valid / o_cfg_ready   index 0 file_length, 1 target_chunk_id
//
// one byte a cycle sustained while the m side takes results: the byte sits in the
// input register, the walk logic (tag compares, size assembly, a 34-bit add and
// compare) settles combinationally and writes the result register
// a result passes from the input register through the result register to the
// m side, after the byte handshake
// synchronous active-low reset; file_length clears, target defaults to iXML
// a stall on the m side holds the result register and then the input register
// bytes that give no result still need a free result slot to move on
`timescale 1ns / 1ps
`default_nettype none

module riff_chunk_finder (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input byte stream
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [7:0]   i_s_tdata,   // [7:0] data_byte
    input  wire logic         i_s_tuser,   // [0] first_byte
    // result stream
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [7:0]        o_m_tdata,   // [7:0] payload_byte
    output logic [3:0]        o_m_tuser,   // [0] payload_valid, [3:1] status
    output logic              o_m_tlast,   // is_last
    // configuration writes
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic         i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);
    import rcf_pkg::*;

    // configuration registers
    logic [31:0] r_file_length;
    logic [31:0] r_target_id;

    logic        res_valid;
    t_result     res;
    logic        out_free;
    t_result     out_res;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_length <= '0;
            r_target_id   <= DEFAULT_TARGET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FILE_LENGTH: r_file_length <= i_cfg_data;
                CFG_TARGET_ID:   r_target_id   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // header check and chunk walk, one byte per advance
    rcf_walker u_walker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_data_byte   (i_s_tdata),
        .i_first_byte  (i_s_tuser),
        .i_file_length (r_file_length),
        .i_target_id   (r_target_id),
        .i_out_free    (out_free),
        .o_res_valid   (res_valid),
        .o_result      (res)
    );

    // result register facing the m side
    rcf_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (res),
        .i_ready  (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_result (out_res),
        .o_free   (out_free)
    );

    assign o_m_tdata = out_res.payload_byte;
    assign o_m_tuser = {out_res.status, out_res.payload_valid};
    assign o_m_tlast = out_res.is_last;

endmodule

`default_nettype wire
